// File: rtl/mhf_pkg.sv
// Shared types, constants and CRC helper for the multicast hash filter.
package mhf_pkg;

  localparam int unsigned AddrW     = 48;
  localparam int unsigned AddrBytes = 6;
  localparam int unsigned CntW      = $clog2(AddrBytes);
  localparam int unsigned BinW      = 6;
  localparam int unsigned BinShift  = 26;
  localparam int unsigned TableW    = 64;
  localparam int unsigned WordW     = 32;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 72;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture a new address, preset CRC
    logic step;    // fold one address byte into the CRC
    logic commit;  // update table, load result register
  } mhf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic group;   // captured address has the group bit set
  } mhf_sts_t;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    logic [7:0]  v;
    logic        fb;
    c = crc_in;
    v = data;
    for (int b = 0; b < 8; b++) begin
      fb = c[0] ^ v[0];
      c  = {1'b0, c[31:1]};
      if (fb) begin
        c = c ^ CrcPoly;
      end
      v = {1'b0, v[7:1]};
    end
    return c;
  endfunction

endpackage

// File: rtl/mhf_datapath.sv
// Datapath: address shifter, byte-wise CRC register, hash table and result register.
module mhf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mhf_pkg::mhf_cmd_t             cmd_i,
  output mhf_pkg::mhf_sts_t             sts_o,
  input  logic [mhf_pkg::AddrW-1:0]     addr_i,
  output logic                          status_o,
  output logic [mhf_pkg::BinW-1:0]      bin_o,
  output logic [mhf_pkg::WordW-1:0]     table_lo_o,
  output logic [mhf_pkg::WordW-1:0]     table_hi_o
);

  logic [mhf_pkg::AddrW-1:0]  addr_q, addr_d;
  logic [31:0]                crc_q, crc_d;
  logic                       grp_q, grp_d;
  logic [mhf_pkg::TableW-1:0] table_q, table_d;
  logic                       status_q, status_d;
  logic [mhf_pkg::BinW-1:0]   bin_q, bin_d;
  logic [mhf_pkg::TableW-1:0] tout_q, tout_d;
  logic [mhf_pkg::BinW-1:0]   bin_sel;

  assign bin_sel = crc_q[mhf_pkg::BinShift +: mhf_pkg::BinW];

  always_comb begin
    addr_d   = addr_q;
    crc_d    = crc_q;
    grp_d    = grp_q;
    table_d  = table_q;
    status_d = status_q;
    bin_d    = bin_q;
    tout_d   = tout_q;
    if (cmd_i.load) begin
      addr_d = addr_i;
      crc_d  = mhf_pkg::CrcInit;
      grp_d  = addr_i[mhf_pkg::AddrW-8];  // bit 0 of first byte
    end else if (cmd_i.step) begin
      crc_d  = mhf_pkg::crc_byte(crc_q, addr_q[mhf_pkg::AddrW-1 -: 8]);
      addr_d = {addr_q[mhf_pkg::AddrW-9:0], 8'h00};
    end
    if (cmd_i.commit) begin
      if (grp_q) begin
        table_d  = table_q | (mhf_pkg::TableW'(1) << bin_sel);
        status_d = mhf_pkg::STATUS_OK;
        bin_d    = bin_sel;
      end else begin
        status_d = mhf_pkg::STATUS_REJECT;
        bin_d    = '0;
      end
      tout_d = table_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q <= '0;
    end else begin
      table_q <= table_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    crc_q    <= crc_d;
    grp_q    <= grp_d;
    status_q <= status_d;
    bin_q    <= bin_d;
    tout_q   <= tout_d;
  end

  assign sts_o.group = grp_q;
  assign status_o    = status_q;
  assign bin_o       = bin_q;
  assign table_lo_o  = tout_q[mhf_pkg::WordW-1:0];
  assign table_hi_o  = tout_q[mhf_pkg::TableW-1:mhf_pkg::WordW];

endmodule

// File: rtl/mhf_ctrl.sv
// Controller: sequences load, CRC byte steps and commit; owns both handshakes.
module mhf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mhf_pkg::mhf_cmd_t cmd_o,
  input  mhf_pkg::mhf_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CRC,
    S_DONE
  } state_e;

  localparam logic [mhf_pkg::CntW-1:0] LastStep = mhf_pkg::CntW'(mhf_pkg::AddrBytes - 1);

  state_e                    state_q;
  logic [mhf_pkg::CntW-1:0]  cnt_q;
  logic                      ovalid_q;
  logic                      slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign slot_free   = !ovalid_q || out_ready_i;

  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == S_CRC) && sts_i.group;
    cmd_o.commit = (state_q == S_DONE) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      // a commit reloads the output register even as the old result leaves
      if (state_q == S_DONE && slot_free) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CRC;
            cnt_q   <= '0;
          end
        end
        S_CRC: begin
          // unicast skips the hash entirely
          if (!sts_i.group || cnt_q == LastStep) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastStep) else $error("byte counter out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CRC && cnt_q == '0))
    else $error("accepted request did not start CRC");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC && sts_i.group && cnt_q == LastStep) |=> state_q == S_DONE)
    else $error("CRC did not finish after last byte");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o) else $error("commit without result valid");

endmodule

// File: rtl/multicast_hash_filter_register_unit.sv
// Top level of the multicast hash filter register unit.
//
// Slave stream: one request per beat, tdata = 48-bit destination MAC address
// with the first transmitted byte in bits 47:40.
// Master stream: one result per request, tdata packs from bit 0 up:
// status (1), bin_index (6), table_low_word (32), table_high_word (32), pad (1).
// A multicast address (group bit set) is hashed with a reflected CRC-32
// (poly 0xEDB88320, init all ones, no final xor), one address byte per cycle
// through the datapath CRC register; CRC bits 31:26 pick the bin to set in the
// 64-bit table. A unicast address is rejected (status 1, bin 0) and the table
// is untouched; both table words are always reported.
// After acceptance a multicast request takes six CRC byte steps and then a
// commit; a unicast request passes through the CRC state without a step and
// then commits. A new request is accepted only once the last has committed,
// as the single byte-wide CRC step is reused six times.
// Reset clears the hash table and all handshake state.
// The result sits in an output register; a new request may be accepted while
// it waits, and the next commit holds off until the receiver takes it.
module multicast_hash_filter_register_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [47:0] mac_address
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [0] status, [6:1] bin_index,
                                        // [38:7] table_low_word,
                                        // [70:39] table_high_word, [71] zero
);

  mhf_pkg::mhf_cmd_t            cmd;
  mhf_pkg::mhf_sts_t            sts;
  logic                         status;
  logic [mhf_pkg::BinW-1:0]     bin;
  logic [mhf_pkg::WordW-1:0]    tlo;
  logic [mhf_pkg::WordW-1:0]    thi;

  mhf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mhf_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .addr_i     (s_axis_tdata_i),
    .status_o   (status),
    .bin_o      (bin),
    .table_lo_o (tlo),
    .table_hi_o (thi)
  );

  // Result packing, low field first, padded to whole bytes
  assign m_axis_tdata_o = {1'b0, thi, tlo, bin, status};

endmodule

// File: sim/tb_multicast_hash_filter_register_unit.sv
// Testbench for the multicast hash filter register unit.
`timescale 1ns / 100ps

module tb_multicast_hash_filter_register_unit;

  // One result as it leaves the master stream
  typedef struct packed {
    logic                      pad;
    logic [mhf_pkg::WordW-1:0] table_high_word;
    logic [mhf_pkg::WordW-1:0] table_low_word;
    logic [mhf_pkg::BinW-1:0]  bin_index;
    logic                      status;
  } filter_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [mhf_pkg::InDataW-1:0]  s_axis_tdata_i;   // [47:0] mac_address
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [mhf_pkg::OutDataW-1:0] m_axis_tdata_o;   // [0] status, [6:1] bin_index,
                                                  // [38:7] table_low_word,
                                                  // [70:39] table_high_word,
                                                  // [71] zero

  logic [mhf_pkg::TableW-1:0] filter_table;       // predicted hash table
  filter_result_t    pending_results[$]; // predicted results, oldest first
  int                error_count;
  int                results_checked;
  int                registered_count;
  int                rejected_count;
  int                burst_left;
  int                stall_cycle;
  int                stall_mode;

  multicast_hash_filter_register_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Hash one address and fold it into the predicted table
  function automatic filter_result_t predict_filter_update(
    input logic [mhf_pkg::AddrW-1:0] mac
  );
    logic [31:0]    crc;
    logic [7:0]     octet;
    logic           fb;
    filter_result_t res;
    res = '0;
    if (!mac[40]) begin
      res.status = mhf_pkg::STATUS_REJECT;
      rejected_count++;
    end else begin
      crc = mhf_pkg::CrcInit;
      for (int i = 0; i < mhf_pkg::AddrBytes; i++) begin
        octet = mac[mhf_pkg::AddrW-1-8*i -: 8];  // first byte on the wire first
        for (int b = 0; b < 8; b++) begin
          fb  = crc[0] ^ octet[b];
          crc = crc >> 1;
          if (fb) begin
            crc = crc ^ mhf_pkg::CrcPoly;
          end
        end
      end
      res.status    = mhf_pkg::STATUS_OK;
      res.bin_index = crc[mhf_pkg::BinShift +: mhf_pkg::BinW];
      filter_table[res.bin_index] = 1'b1;
      registered_count++;
    end
    res.table_low_word  = filter_table[mhf_pkg::WordW-1:0];
    res.table_high_word = filter_table[mhf_pkg::TableW-1:mhf_pkg::WordW];
    return res;
  endfunction

  // Random gap between bursts; a gap of zero keeps valid high across bursts
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Offer one request and wait for its acceptance; valid is left high
  task automatic send_address(input logic [mhf_pkg::AddrW-1:0] mac);
    pace_sender();
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= mac;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    pending_results.push_back(predict_filter_update(mac));
  endtask

  task automatic wait_results_drained(input int limit);
    int waited;
    waited = 0;
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  function automatic logic [mhf_pkg::AddrW-1:0] random_address(input bit group);
    logic [mhf_pkg::AddrW-1:0] mac;
    logic [31:0]               upper;
    mac[31:0]                = $urandom;
    upper                    = $urandom;
    mac[mhf_pkg::AddrW-1:32] = upper[15:0];
    mac[40]                  = group;
    return mac;
  endfunction

  // Receiver stall pattern: always ready, coin toss, or long stalls
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 48 == 0) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    filter_result_t got;
    filter_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.bin_index !== want.bin_index) begin
          $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
          error_count++;
        end
        if (got.table_low_word !== want.table_low_word) begin
          $error("table_low_word: expected %h, got %h",
                 want.table_low_word, got.table_low_word);
          error_count++;
        end
        if (got.table_high_word !== want.table_high_word) begin
          $error("table_high_word: expected %h, got %h",
                 want.table_high_word, got.table_high_word);
          error_count++;
        end
        if (got.pad !== 1'b0) begin
          $error("pad: expected 0, got %b", got.pad);
          error_count++;
        end
      end
    end
  end

  // Corner addresses, group bit alone, familiar multicast prefixes
  task automatic test_corner_addresses();
    send_address(48'h0000_0000_0000);  // unicast on an empty table
    send_address(48'hFFFF_FFFF_FFFF);  // broadcast
    send_address(48'h0100_0000_0000);  // group bit only
    send_address(48'hFEFF_FFFF_FFFF);  // every bit but the group bit
    send_address(48'h0100_5E00_0001);
    send_address(48'h0100_5E7F_FFFF);
    send_address(48'h3333_0000_0001);
    send_address(48'h3333_FFFF_FFFF);
    send_address(48'h0180_C200_000E);
    send_address(48'h0000_5E00_0101);  // unicast, table must still read back
    send_address(48'hAAAA_AAAA_AAAA);  // unicast
    send_address(48'h5555_5555_5555);  // multicast
  endtask

  // Same bin twice: table unchanged, status still registered
  task automatic test_repeated_bins();
    send_address(48'hFFFF_FFFF_FFFF);
    send_address(48'h0100_5E00_0001);
    send_address(48'h0100_5E00_0001);
    send_address(48'h0100_0000_0000);
    send_address(48'h0200_0000_0001);  // unicast, bits 41 and 0 set, group bit clear
  endtask

  // Walking one through the address, first with and then without the group bit
  task automatic test_walking_bits();
    for (int i = 0; i < 4; i++) begin
      send_address(48'h0100_0000_0000 | (48'h1 << (i * 11)));
    end
    send_address(48'h8000_0000_0000);
    send_address(48'h0080_0000_0000);
  endtask

  // Random traffic, about three quarters multicast, some addresses replayed
  task automatic test_random_traffic(input int count);
    logic [mhf_pkg::AddrW-1:0] recent[$];
    logic [mhf_pkg::AddrW-1:0] mac;
    for (int n = 0; n < count; n++) begin
      if (recent.size() != 0 && $urandom_range(0, 9) == 0) begin
        mac = recent[$urandom_range(0, recent.size() - 1)];
      end else begin
        mac = random_address($urandom_range(0, 3) != 0);
      end
      recent.push_back(mac);
      if (recent.size() > 16) begin
        void'(recent.pop_front());
      end
      send_address(mac);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    s_axis_tvalid_i  = 1'b0;
    s_axis_tdata_i   = '0;
    m_axis_tready_i  = 1'b0;
    filter_table     = '0;
    error_count      = 0;
    results_checked  = 0;
    registered_count = 0;
    rejected_count   = 0;
    burst_left       = 0;
    stall_cycle      = 0;
    stall_mode       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_addresses();
    test_repeated_bins();
    test_walking_bits();
    test_random_traffic(260);
    // hold the sender until every request is answered
    wait_results_drained(20000);
    burst_left = 0;
    test_random_traffic(290);

    wait_results_drained(20000);
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("Checked %0d results: %0d registered, %0d rejected unicast addresses,",
             results_checked, registered_count, rejected_count);
    $display("final table %h with %0d of 64 bins set", filter_table,
             $countones(filter_table));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
